FILE: rtl/csrd_pkg.sv
// types and constants shared by the sprite rle decoder
package csrd_pkg;

  localparam int CoordW = 11;
  localparam int PixXW = 12;
  localparam int ByteW = 8;
  localparam int RunW = 7;
  localparam int HdrW = 4;

  localparam logic [CoordW-1:0] CNT_MAX = '1;
  localparam int HEADER_BYTES = 11;
  localparam logic [HdrW-1:0] HDR_SKIP = HdrW'(HEADER_BYTES - 2);
  localparam logic signed [ByteW-1:0] HDR_MARK = 8'sd10;
  localparam logic [CoordW-1:0] LINE_WIDTH_RST = 11'd640;

  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_HELD,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH,
    REG_BASE_X,
    REG_BASE_Y,
    REG_CLIP_TOP
  } cfg_reg_t;

endpackage

FILE: rtl/cel_sprite_rle_decoder.sv
// sprite rle decoder: frame bytes in, clipped screen pixels out
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | in_valid / in_stall       | data_byte, frame_start
//  out     | out_valid / out_stall     | pixel_x, pixel_y, pixel_value
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one byte per cycle while in_stall is low; each byte is decoded in the cycle it
// is taken and its pixel, if any, lands in the output register on the same edge
// in_stall is raised only while the output register holds a pixel that is stalled
// rst clears decode state and loads the register defaults; cfg_ready is always high
module cel_sprite_rle_decoder #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [7:0]             data_byte,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [11:0]                   pixel_x,
  output logic [10:0]                   pixel_y,
  output logic [7:0]                    pixel_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  csrd_pkg::cfg_reg_t            cfg_index,
  input  logic [10:0]                   cfg_data
);
  import csrd_pkg::*;

  localparam logic [CoordW+1:0] MaxW = (CoordW+2)'(MAX_WIDTH);

  logic [CoordW-1:0] line_width, base_x, base_y, clip_top;

  phase_t            phase, phase_next, ph;
  logic [HdrW-1:0]   header_left, header_left_next, hl;
  logic [RunW-1:0]   literal_left, literal_left_next, ll;
  logic [CoordW-1:0] column, column_next, col;
  logic [CoordW-1:0] row_up, row_up_next, row;
  logic              stopped, stopped_next, stp;

  logic              acc;
  logic              do_ctl, clip, wrap, emit;
  logic signed [ByteW-1:0] ctl_v;
  logic [ByteW-1:0]  skip;
  logic [CoordW+1:0] w;
  logic signed [CoordW+1:0] row_diff;
  logic [CoordW-1:0] col_w, row_w, pc, pr;
  logic [CoordW:0]   col_sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign acc       = in_valid & ~in_stall;

  // state after an optional frame restart
  assign ph  = frame_start ? PH_AWAIT : phase;
  assign hl  = frame_start ? '0 : header_left;
  assign ll  = frame_start ? '0 : literal_left;
  assign col = frame_start ? '0 : column;
  assign row = frame_start ? '0 : row_up;
  assign stp = frame_start ? 1'b0 : stopped;

  always_comb begin
    phase_next = ph;
    if (!stp) begin
      case (ph)
        PH_AWAIT: phase_next = (data_byte == HDR_MARK) ? PH_HELD : PH_BODY;
        PH_HELD:  phase_next = PH_BODY;
        PH_BODY:  phase_next = PH_BODY;
        default:  phase_next = PH_AWAIT;
      endcase
    end
  end

  always_comb begin
    w = ({2'b0, line_width} > MaxW) ? MaxW : {2'b0, line_width};
    row_diff = $signed({2'b0, base_y}) - $signed({2'b0, row});
    clip = row_diff < $signed({2'b0, clip_top});
    wrap = {2'b0, col} >= w;
    col_w = wrap ? '0 : col;
    row_w = (wrap && row != CNT_MAX) ? row + 1'b1 : row;
    ctl_v = (ph == PH_HELD) ? HDR_MARK : data_byte;
    skip = ~ctl_v + 1'b1;
    col_sum = {1'b0, col_w} + {4'b0, skip};

    do_ctl = 1'b0;
    emit = 1'b0;
    header_left_next = hl;
    literal_left_next = ll;
    column_next = col;
    row_up_next = row;
    stopped_next = stp;
    pc = col;
    pr = row;

    if (!stp) begin
      case (ph)
        PH_AWAIT: begin
          if (data_byte != HDR_MARK) begin
            do_ctl = (ll == '0);
            emit = (ll != '0);
          end
        end
        PH_HELD: begin
          if (data_byte == '0) begin
            header_left_next = HDR_SKIP;
          end else begin
            do_ctl = 1'b1;
          end
        end
        PH_BODY: begin
          if (hl != '0) begin
            header_left_next = hl - 1'b1;
          end else begin
            do_ctl = (ll == '0);
            emit = (ll != '0);
          end
        end
        default: ;
      endcase
    end

    if (do_ctl) begin
      if (clip) begin
        stopped_next = 1'b1;
      end else begin
        column_next = col_w;
        row_up_next = row_w;
        if (ctl_v >= 0) begin
          literal_left_next = ctl_v[RunW-1:0];
        end else begin
          column_next = col_sum[CoordW] ? CNT_MAX : col_sum[CoordW-1:0];
        end
        // a false header run emits its first pixel from this same byte
        if (ph == PH_HELD) begin
          emit = 1'b1;
          pc = col_w;
          pr = row_w;
        end
      end
    end

    if (emit) begin
      literal_left_next = ((ph == PH_HELD) ? HDR_MARK[RunW-1:0] : ll) - 1'b1;
      column_next = (pc == CNT_MAX) ? pc : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
      base_x <= '0;
      base_y <= '0;
      clip_top <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_WIDTH: line_width <= cfg_data;
        REG_BASE_X:     base_x <= cfg_data;
        REG_BASE_Y:     base_y <= cfg_data;
        REG_CLIP_TOP:   clip_top <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_AWAIT;
      header_left <= '0;
      literal_left <= '0;
      column <= '0;
      row_up <= '0;
      stopped <= 1'b0;
    end else if (acc) begin
      phase <= phase_next;
      header_left <= header_left_next;
      literal_left <= literal_left_next;
      column <= column_next;
      row_up <= row_up_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      pixel_x <= {1'b0, base_x} + {1'b0, pc};
      pixel_y <= base_y - pr;
      pixel_value <= data_byte;
    end
  end

  a_stall_needs_pixel: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pixel pending");

  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    (acc && stopped && !frame_start) |=> !out_valid)
    else $error("pixel emitted after clip stop");

  a_header_in_body: assert property (@(posedge clk) disable iff (rst)
    (header_left != '0) |-> (phase == PH_BODY))
    else $error("header skip outside body phase");

  a_run_in_body: assert property (@(posedge clk) disable iff (rst)
    (literal_left != '0) |-> (phase == PH_BODY))
    else $error("literal run outside body phase");

endmodule

FILE: bench/cel_sprite_rle_decoder_test.sv
// self-checking bench for the sprite rle decoder: random frames against a built-in pixel predictor
module cel_sprite_rle_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csrd_pkg::*;

  localparam int MAX_W = 1024;

  typedef struct packed {
    logic [7:0] b;
    logic       fs;
  } frame_byte_t;

  typedef struct packed {
    logic [11:0] x;
    logic [10:0] y;
    logic [7:0]  v;
  } pixel_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [7:0]  data_byte;
  logic               frame_start;
  logic               out_valid;
  logic               out_stall;
  logic [11:0]        pixel_x;
  logic [10:0]        pixel_y;
  logic [7:0]         pixel_value;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_reg_t           cfg_index;
  logic [10:0]        cfg_data;

  cel_sprite_rle_decoder dut (.*);

  // register copies
  logic [10:0] line_width, base_x, base_y, clip_top;
  // decode state
  phase_t      phase;
  logic [7:0]  held;
  logic [3:0]  hdr_left;
  logic [6:0]  lit_left;
  logic [10:0] column, row_up;
  bit          halted;

  frame_byte_t frame_bytes[$];
  pixel_t      due_pixels[$];
  frame_byte_t cur_byte;
  pixel_t      want;
  bit          start_flag;
  int          send_idle_pct, recv_stall_pct;
  int          errors, bytes_taken, pixels_seen, frames, settings;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic restart_frame();
    phase = PH_AWAIT;
    held = '0;
    hdr_left = '0;
    lit_left = '0;
    column = '0;
    row_up = '0;
    halted = 1'b0;
  endtask

  task automatic run_control(input int v);
    int w, row, nc;
    w = (int'(line_width) > MAX_W) ? MAX_W : int'(line_width);
    row = int'(base_y) - int'(row_up);
    if (row < int'(clip_top)) begin
      halted = 1'b1;
      return;
    end
    if (int'(column) >= w) begin
      column = '0;
      if (row_up != CNT_MAX) row_up = row_up + 1'b1;
    end
    if (v >= 0) begin
      lit_left = v[6:0];
    end else begin
      nc = int'(column) - v;
      column = (nc > int'(CNT_MAX)) ? CNT_MAX : nc[10:0];
    end
  endtask

  task automatic body_byte(input logic [7:0] raw);
    pixel_t p;
    if (lit_left != 0) begin
      p.x = {1'b0, base_x} + {1'b0, column};
      p.y = base_y - row_up;
      p.v = raw;
      due_pixels.push_back(p);
      lit_left = lit_left - 1'b1;
      if (column != CNT_MAX) column = column + 1'b1;
    end else begin
      run_control(int'($signed(raw)));
    end
  endtask

  task automatic decode_byte(input logic [7:0] raw, input logic fs);
    if (fs) restart_frame();
    if (halted) return;
    case (phase)
      PH_AWAIT: begin
        if ($signed(raw) == HDR_MARK) begin
          held = raw;
          phase = PH_HELD;
        end else begin
          phase = PH_BODY;
          body_byte(raw);
        end
      end
      PH_HELD: begin
        phase = PH_BODY;
        if (raw == 8'd0) begin
          hdr_left = HDR_SKIP;
        end else begin
          run_control(int'(held & 8'h7f));
          if (!halted) body_byte(raw);
        end
      end
      default: begin
        if (hdr_left != 0) hdr_left = hdr_left - 1'b1;
        else body_byte(raw);
      end
    endcase
  endtask

  // byte sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(data_byte, frame_start);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (frame_bytes.size() != 0 &&
            !(send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)) begin
          cur_byte = frame_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= cur_byte.b;
          frame_start <= cur_byte.fs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel x=%0d y=%0d v=%0d", $time,
                   pixel_x, pixel_y, pixel_value);
        end else begin
          want = due_pixels.pop_front();
          pixels_seen++;
          if (want.x !== pixel_x || want.y !== pixel_y || want.v !== pixel_value) begin
            errors++;
            $display("%0t: pixel mismatch, expected x=%0d y=%0d v=%0d, got x=%0d y=%0d v=%0d",
                     $time, want.x, want.y, want.v, pixel_x, pixel_y, pixel_value);
          end
        end
      end
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic put(input int b);
    frame_bytes.push_back('{b[7:0], start_flag});
    start_flag = 1'b0;
  endtask

  task automatic add_frame();
    int hdr, groups, kind, n;
    frames++;
    start_flag = ($urandom_range(0, 9) != 0);
    hdr = $urandom_range(0, 9);
    if (hdr < 5) begin
      put(10);
      put(0);
      repeat (HEADER_BYTES - 2) put($urandom_range(0, 255));
    end else if (hdr == 5) begin
      put(10);
      put($urandom_range(1, 255));
    end
    groups = $urandom_range(2, 16);
    repeat (groups) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 127) : $urandom_range(0, 12);
        put(n);
        repeat (n) put($urandom_range(0, 255));
      end else if (kind < 9) begin
        put($urandom_range(128, 255));
      end else begin
        put($urandom_range(0, 255));
      end
    end
  endtask

  task automatic settle(input int extra);
    int waited;
    waited = 0;
    while ((frame_bytes.size() != 0 || in_valid || due_pixels.size() != 0) &&
           waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= 200000) begin
      errors++;
      $display("%0t: stream did not drain, %0d bytes left", $time, frame_bytes.size());
    end
    if (due_pixels.size() != 0) begin
      errors += due_pixels.size();
      $display("%0t: %0d expected pixels never arrived", $time, due_pixels.size());
      due_pixels.delete();
    end
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [10:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LINE_WIDTH: line_width = val;
      REG_BASE_X:     base_x = val;
      REG_BASE_Y:     base_y = val;
      default:        clip_top = val;
    endcase
  endtask

  task automatic set_regs(input logic [10:0] lw, bx, by, ct, input int send, recv);
    settle(4);
    write_reg(REG_LINE_WIDTH, lw);
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Y, by);
    write_reg(REG_CLIP_TOP, ct);
    @(negedge clk);
    send_idle_pct = send;
    recv_stall_pct = recv;
    settings++;
  endtask

  task automatic random_phase(input logic [10:0] lw, bx, by, ct, input int send, recv);
    int target;
    set_regs(lw, bx, by, ct, send, recv);
    target = bytes_taken + 40;
    while (bytes_taken + frame_bytes.size() < target) add_frame();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    frame_start = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LINE_WIDTH;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    line_width = LINE_WIDTH_RST;
    base_x = '0;
    base_y = '0;
    clip_top = '0;
    restart_frame();

    // no frame start after reset, false header then extreme literals
    start_flag = 1'b0;
    put(10); put(3); put(8'h7f); put(8'h80); put(8'hff);
    // proper header, skips, empty run, a one-pixel run and the start of a maximal run
    start_flag = 1'b1;
    put(10); put(0);
    repeat (HEADER_BYTES - 2) put(8'haa);
    put(8'h80); put(8'hff); put(0); put(1); put(8'h55); put(8'h7f); put(8'h01);
    frames = 2;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    random_phase(11'd16, 11'd100, 11'd50, 11'd40, 0, 0);
    random_phase(11'd1024, 11'd2047, 11'd2047, 11'd0, 67, 0);
    random_phase(11'd2047, 11'd0, 11'd0, 11'd0, 0, 67);
    random_phase(11'd0, 11'd1000, 11'd300, 11'd295, 23, 23);
    random_phase(11'd1, 11'd2047, 11'd10, 11'd0, 67, 0);
    random_phase(11'd7, 11'd500, 11'd2047, 11'd2047, 0, 67);

    // every control wraps: the row counter climbs on each control byte
    set_regs(11'd0, 11'd2047, 11'd2047, 11'd0, 23, 23);
    frames++;
    start_flag = 1'b1;
    put(8'h80);
    repeat (60) begin
      if ($urandom_range(0, 19) == 0) begin
        put(1);
        put($urandom_range(0, 255));
      end else begin
        put($urandom_range(128, 255));
      end
    end

    settle(4);
    $display("%0d frames across %0d register settings plus reset defaults", frames, settings);
    $display("%0d bytes taken, %0d pixels checked", bytes_taken, pixels_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
